// ----- design/c8x_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, constants and helpers of the CHIP-8 instruction execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam int C8X_STACK_DEPTH   = 16;
    localparam int C8X_MEMORY_BYTES  = 4096;
    localparam int C8X_SCREEN_WIDTH  = 64;
    localparam int C8X_SCREEN_HEIGHT = 32;

    localparam logic [11:0] C8X_START_RESET = 12'd512;
    localparam logic [11:0] C8X_FONT_RESET  = 12'd80;

    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_ROW   = 2'd3
    } c8x_action_t;

    typedef enum logic {
        REG_START_ADDRESS = 1'b0,
        REG_FONT_BASE     = 1'b1
    } c8x_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SVC,
        ST_SVC_RD,
        ST_RD_X,
        ST_RD_Y,
        ST_RD_0,
        ST_EXEC,
        ST_WR_VF,
        ST_BCD,
        ST_ST_RD,
        ST_ST_WR,
        ST_LD_RD,
        ST_LD_WR,
        ST_DR_MODX,
        ST_DR_MODY,
        ST_DR_RD,
        ST_DR_WR,
        ST_DONE
    } c8x_state_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } c8x_bcd_t;

    function automatic c8x_bcd_t c8x_bcd(input logic [7:0] v);
        c8x_bcd_t   d;
        logic [7:0] r;
        logic [15:0] p;
        if (v >= 8'd200) begin
            d.hundreds = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            d.hundreds = 4'd1;
            r = v - 8'd100;
        end else begin
            d.hundreds = 4'd0;
            r = v;
        end
        p = 16'(r) * 16'd205;
        d.tens = p[14:11];
        d.ones = 4'(r - 8'(d.tens) * 8'd10);
        return d;
    endfunction

endpackage : c8x_pkg
`default_nettype wire

// ----- design/c8x_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_mem
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module c8x_mem #(
    parameter int DEPTH = 4096
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire logic [7:0]                 wdata,
    output logic      [7:0]                 rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : c8x_mem
`default_nettype wire

// ----- design/chip8_instruction_execute_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_execute_unit
// Executes one CHIP-8 opcode or one memory/display service action per transfer.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Each item runs through a small
// sequencer built around a single-port byte memory, a register file with one
// read and one write port, and a display row store with one port. An 8xy
// opcode that sets VF writes it in a step of its own; Fx33 writes its three
// digits one by one; Fx55/Fx65 take a read and a write step per register
// moved. A sprite draw first brings Vx below the width and Vy below the
// height by repeated subtraction, then reads and writes each row in turn; a
// draw of height zero skips both and only clears VF. The input is not ready
// while an item is in work, and a stalled result holds the sequencer in its
// last state. No clearing pass runs after reset.
module chip8_instruction_execute_unit
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH   = C8X_STACK_DEPTH,
    parameter int MEMORY_BYTES  = C8X_MEMORY_BYTES,
    parameter int SCREEN_WIDTH  = C8X_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = C8X_SCREEN_HEIGHT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [15:0] s_opcode,
    input  wire logic [7:0]  s_random_byte,
    input  wire logic [15:0] s_key_mask,
    input  wire logic [7:0]  s_delay_now,
    input  wire logic [11:0] s_mem_addr,
    input  wire logic [7:0]  s_mem_data,
    input  wire logic [4:0]  s_row_index,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [11:0] m_pc,
    output logic      [11:0] m_index_reg,
    output logic             m_waiting_for_key,
    output logic             m_delay_load_valid,
    output logic             m_sound_load_valid,
    output logic      [7:0]  m_timer_load_value,
    output logic      [7:0]  m_read_byte,
    output logic      [63:0] m_row_bits,
    output logic             m_unknown_opcode
);

    localparam int MAW  = $clog2(MEMORY_BYTES);
    localparam int SPW  = $clog2(STACK_DEPTH);
    localparam int RowW = $clog2(SCREEN_HEIGHT);
    localparam int W    = SCREEN_WIDTH;
    localparam int H    = SCREEN_HEIGHT;

    function automatic logic [MAW-1:0] mem_wrap(input logic [11:0] a);
        logic [12:0] t;
        t = {1'b0, a};
        for (int k = 0; k < 8; k++) begin
            if (t >= 13'(MEMORY_BYTES)) begin
                t = t - 13'(MEMORY_BYTES);
            end
        end
        return t[MAW-1:0];
    endfunction

    c8x_state_t state_reg, state_next;

    logic [11:0] start_reg, font_reg;
    logic [11:0] pc_reg, index_reg;
    logic [SPW-1:0] sp_reg, sp_dec, sp_inc;
    logic        kwa_reg;
    logic [3:0]  held_reg;

    logic [1:0]  act_reg;
    logic [15:0] op_reg;
    logic [7:0]  rnd_reg, dly_now_reg;
    logic [15:0] keys_reg;
    logic [11:0] maddr_reg;
    logic [7:0]  mdata_reg;
    logic [4:0]  row_idx_reg;
    logic        row_ok_reg;

    logic        dly_reg, snd_reg, unk_reg;
    logic [7:0]  tval_reg, rbyte_reg;
    logic [63:0] rbits_reg;

    logic [7:0]  vx_reg, vy_reg, vf_val_reg;
    logic [7:0]  xm_reg, ym_reg;
    logic [RowW-1:0] row_reg;
    logic [4:0]  cnt_reg;
    logic        flag_reg;

    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn, pc2, addr_sum;
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_kk  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];
    assign pc2    = pc_reg + 12'd2;
    assign addr_sum = index_reg + 12'(cnt_reg);
    assign sp_dec = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;

    // register file
    logic [7:0] vregs [16];
    logic [3:0] v_raddr, v_waddr;
    logic [7:0] v_rdata_reg, v_wdata;
    logic       v_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 16; k++) begin
                vregs[k] <= 8'd0;
            end
        end else if (v_we) begin
            vregs[v_waddr] <= v_wdata;
        end
        v_rdata_reg <= vregs[v_raddr];
    end

    // call stack
    logic [11:0] stack [STACK_DEPTH];
    logic [11:0] stack_q_reg;
    logic        stack_we;

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack[sp_reg] <= pc2;
        end
        stack_q_reg <= stack[sp_dec];
    end

    // main memory
    logic [MAW-1:0] mem_addr;
    logic [7:0]     mem_wdata, mem_rdata;
    logic           mem_we;

    c8x_mem #(
        .DEPTH (MEMORY_BYTES)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // display rows
    logic [W-1:0]    frame [H];
    logic [H-1:0]    fvalid_reg;
    logic [W-1:0]    frame_q_reg, fq, fmask;
    logic            fvalid_q_reg;
    logic [RowW-1:0] f_addr;
    logic            f_we, f_clear;

    always_ff @(posedge aclk) begin
        if (f_we) begin
            frame[row_reg] <= fq ^ fmask;
        end
        frame_q_reg  <= frame[f_addr];
        fvalid_q_reg <= fvalid_reg[f_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || f_clear) begin
            fvalid_reg <= '0;
        end else if (f_we) begin
            fvalid_reg[row_reg] <= 1'b1;
        end
    end

    assign fq = fvalid_q_reg ? frame_q_reg : '0;

    always_comb begin
        logic [7:0] col;
        fmask = '0;
        for (int b = 0; b < 8; b++) begin
            col = xm_reg + 8'(b);
            if (col >= 8'(W)) begin
                col = col - 8'(W);
            end
            if (mem_rdata[7-b]) begin
                fmask[W-1-int'(col)] = 1'b1;
            end
        end
    end

    c8x_bcd_t bcd;
    assign bcd = c8x_bcd(vx_reg);

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (c8x_reg_t'(paddr[2]) == REG_FONT_BASE) ? {20'd0, font_reg}
                                                           : {20'd0, start_reg};

    // key wait search
    logic       key_any;
    logic [3:0] key_first;
    always_comb begin
        key_any   = 1'b0;
        key_first = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                key_any   = 1'b1;
                key_first = 4'(k);
            end
        end
    end

    // program counter after execute
    logic [11:0] pc_exec;
    always_comb begin
        pc_exec = pc2;
        unique case (op_reg[15:12])
            4'h0: if (op_reg == 16'h00EE) pc_exec = stack_q_reg;
            4'h1, 4'h2: pc_exec = op_nnn;
            4'h3: if (vx_reg == op_kk) pc_exec = pc2 + 12'd2;
            4'h4: if (vx_reg != op_kk) pc_exec = pc2 + 12'd2;
            4'h5: if (op_n == 4'd0 && vx_reg == vy_reg) pc_exec = pc2 + 12'd2;
            4'h9: if (op_n == 4'd0 && vx_reg != vy_reg) pc_exec = pc2 + 12'd2;
            4'hB: pc_exec = op_nnn + 12'(v_rdata_reg);
            4'hE: begin
                if ((op_kk == 8'h9E && keys_reg[vx_reg[3:0]]) ||
                    (op_kk == 8'hA1 && !keys_reg[vx_reg[3:0]])) begin
                    pc_exec = pc2 + 12'd2;
                end
            end
            4'hF: begin
                if (op_kk == 8'h0A && (!kwa_reg || keys_reg[held_reg])) begin
                    pc_exec = pc_reg;
                end
            end
            default: ;
        endcase
    end

    // VF value of the 8xy group
    logic [7:0] vf_alu;
    always_comb begin
        unique case (op_n)
            4'h4: vf_alu = {7'd0, (9'(vx_reg) + 9'(vy_reg)) > 9'd255};
            4'h5: vf_alu = {7'd0, vx_reg >= vy_reg};
            4'h6: vf_alu = {7'd0, vx_reg[0]};
            4'h7: vf_alu = {7'd0, vy_reg >= vx_reg};
            4'hE: vf_alu = {7'd0, vx_reg[7]};
            default: vf_alu = 8'd0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        v_raddr    = op_x;
        v_we       = 1'b0;
        v_waddr    = op_x;
        v_wdata    = 8'd0;
        mem_we     = 1'b0;
        mem_addr   = mem_wrap(addr_sum);
        mem_wdata  = 8'd0;
        f_addr     = row_reg;
        f_we       = 1'b0;
        f_clear    = 1'b0;
        stack_we   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (c8x_action_t'(s_action) == ACT_EXEC) ? ST_RD_X : ST_SVC;
                end
            end
            ST_SVC: begin
                mem_addr  = mem_wrap(maddr_reg);
                mem_wdata = mdata_reg;
                mem_we    = (c8x_action_t'(act_reg) == ACT_WRITE);
                f_addr    = row_ok_reg ? RowW'(row_idx_reg) : '0;
                state_next = ST_SVC_RD;
            end
            ST_SVC_RD: state_next = ST_DONE;
            ST_RD_X: begin
                v_raddr    = op_x;
                state_next = ST_RD_Y;
            end
            ST_RD_Y: begin
                v_raddr    = op_y;
                state_next = ST_RD_0;
            end
            ST_RD_0: begin
                v_raddr    = 4'd0;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                unique case (op_reg[15:12])
                    4'h0: f_clear = (op_reg == 16'h00E0);
                    4'h2: stack_we = 1'b1;
                    4'h6: begin
                        v_we = 1'b1; v_wdata = op_kk;
                    end
                    4'h7: begin
                        v_we = 1'b1; v_wdata = vx_reg + op_kk;
                    end
                    4'h8: begin
                        state_next = ST_WR_VF;
                        v_we = 1'b1;
                        unique case (op_n)
                            4'h0: begin v_wdata = vy_reg;          state_next = ST_DONE; end
                            4'h1: begin v_wdata = vx_reg | vy_reg; state_next = ST_DONE; end
                            4'h2: begin v_wdata = vx_reg & vy_reg; state_next = ST_DONE; end
                            4'h3: begin v_wdata = vx_reg ^ vy_reg; state_next = ST_DONE; end
                            4'h4: v_wdata = vx_reg + vy_reg;
                            4'h5: v_wdata = vx_reg - vy_reg;
                            4'h6: v_wdata = {1'b0, vx_reg[7:1]};
                            4'h7: v_wdata = vy_reg - vx_reg;
                            4'hE: v_wdata = {vx_reg[6:0], 1'b0};
                            default: begin v_we = 1'b0; state_next = ST_DONE; end
                        endcase
                    end
                    4'hC: begin
                        v_we = 1'b1; v_wdata = rnd_reg & op_kk;
                    end
                    4'hD: state_next = (op_n == 4'd0) ? ST_WR_VF : ST_DR_MODX;
                    4'hF: begin
                        priority case (op_kk)
                            8'h07: begin v_we = 1'b1; v_wdata = dly_now_reg; end
                            8'h0A: begin
                                if (kwa_reg && !keys_reg[held_reg]) begin
                                    v_we = 1'b1; v_wdata = {4'd0, held_reg};
                                end
                            end
                            8'h33: state_next = ST_BCD;
                            8'h55: state_next = ST_ST_RD;
                            8'h65: state_next = ST_LD_RD;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            ST_WR_VF: begin
                v_we = 1'b1; v_waddr = 4'hF; v_wdata = vf_val_reg;
                state_next = ST_DONE;
            end
            ST_BCD: begin
                mem_we = 1'b1;
                mem_wdata = (cnt_reg == 5'd0) ? {4'd0, bcd.hundreds} :
                            (cnt_reg == 5'd1) ? {4'd0, bcd.tens} : {4'd0, bcd.ones};
                if (cnt_reg == 5'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_ST_RD: begin
                v_raddr = cnt_reg[3:0];
                state_next = ST_ST_WR;
            end
            ST_ST_WR: begin
                mem_we = 1'b1; mem_wdata = v_rdata_reg;
                state_next = (cnt_reg[3:0] == op_x) ? ST_DONE : ST_ST_RD;
            end
            ST_LD_RD: state_next = ST_LD_WR;
            ST_LD_WR: begin
                v_we = 1'b1; v_waddr = cnt_reg[3:0]; v_wdata = mem_rdata;
                state_next = (cnt_reg[3:0] == op_x) ? ST_DONE : ST_LD_RD;
            end
            ST_DR_MODX: if (xm_reg < 8'(W)) state_next = ST_DR_MODY;
            ST_DR_MODY: if (ym_reg < 8'(H)) state_next = ST_DR_RD;
            ST_DR_RD: state_next = ST_DR_WR;
            ST_DR_WR: begin
                f_we = 1'b1;
                state_next = (cnt_reg[3:0] == op_n - 4'd1) ? ST_WR_VF : ST_DR_RD;
            end
            ST_DONE: if (!m_valid || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= C8X_START_RESET;
            font_reg  <= C8X_FONT_RESET;
            pc_reg    <= C8X_START_RESET;
            index_reg <= 12'd0;
            sp_reg    <= '0;
            kwa_reg   <= 1'b0;
            held_reg  <= 4'd0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (c8x_reg_t'(paddr[2]) == REG_START_ADDRESS) begin
                    start_reg <= pwdata[11:0];
                    pc_reg    <= pwdata[11:0];
                end else begin
                    font_reg <= pwdata[11:0];
                end
            end
            if (state_reg == ST_DONE && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_EXEC: begin
                    pc_reg <= pc_exec;
                    unique case (op_reg[15:12])
                        4'h0: begin
                            if (op_reg == 16'h00EE) begin
                                sp_reg <= sp_dec;
                            end
                        end
                        4'h2: sp_reg <= sp_inc;
                        4'hA: index_reg <= op_nnn;
                        4'hF: begin
                            priority case (op_kk)
                                8'h0A: begin
                                    if (!kwa_reg) begin
                                        if (key_any) begin
                                            kwa_reg  <= 1'b1;
                                            held_reg <= key_first;
                                        end
                                    end else if (!keys_reg[held_reg]) begin
                                        kwa_reg <= 1'b0;
                                    end
                                end
                                8'h1E: index_reg <= index_reg + 12'(vx_reg);
                                8'h29: index_reg <= font_reg + {2'd0, vx_reg, 2'd0}
                                                             + {4'd0, vx_reg};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                ST_ST_WR: if (cnt_reg[3:0] == op_x) index_reg <= addr_sum + 12'd1;
                ST_LD_WR: if (cnt_reg[3:0] == op_x) index_reg <= addr_sum + 12'd1;
                default: ;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                act_reg     <= s_action;
                op_reg      <= s_opcode;
                rnd_reg     <= s_random_byte;
                keys_reg    <= s_key_mask;
                dly_now_reg <= s_delay_now;
                maddr_reg   <= s_mem_addr;
                mdata_reg   <= s_mem_data;
                row_idx_reg <= s_row_index;
                row_ok_reg  <= 7'(s_row_index) < 7'(H);
                dly_reg     <= 1'b0;
                snd_reg     <= 1'b0;
                unk_reg     <= 1'b0;
                tval_reg    <= 8'd0;
                rbyte_reg   <= 8'd0;
                rbits_reg   <= 64'd0;
                cnt_reg     <= 5'd0;
                flag_reg    <= 1'b0;
            end
            ST_SVC_RD: begin
                if (c8x_action_t'(act_reg) == ACT_READ) begin
                    rbyte_reg <= mem_rdata;
                end
                if (c8x_action_t'(act_reg) == ACT_ROW && row_ok_reg) begin
                    rbits_reg <= 64'(fq) << (64 - W);
                end
            end
            ST_RD_Y: vx_reg <= v_rdata_reg;
            ST_RD_0: vy_reg <= v_rdata_reg;
            ST_EXEC: begin
                xm_reg <= vx_reg;
                ym_reg <= vy_reg;
                vf_val_reg <= (op_reg[15:12] == 4'h8) ? vf_alu : 8'd0;
                unique case (op_reg[15:12])
                    4'h0: unk_reg <= (op_reg != 16'h00E0) && (op_reg != 16'h00EE);
                    4'h5, 4'h9: unk_reg <= (op_n != 4'd0);
                    4'h8: unk_reg <= (op_n > 4'h7) && (op_n != 4'hE);
                    4'hE: unk_reg <= (op_kk != 8'h9E) && (op_kk != 8'hA1);
                    4'hF: begin
                        priority case (op_kk)
                            8'h15: begin dly_reg <= 1'b1; tval_reg <= vx_reg; end
                            8'h18: begin snd_reg <= 1'b1; tval_reg <= vx_reg; end
                            8'h07, 8'h0A, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65: ;
                            default: unk_reg <= 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end
            ST_BCD, ST_ST_WR, ST_LD_WR: cnt_reg <= cnt_reg + 5'd1;
            ST_DR_MODX: if (xm_reg >= 8'(W)) xm_reg <= xm_reg - 8'(W);
            ST_DR_MODY: begin
                if (ym_reg >= 8'(H)) begin
                    ym_reg <= ym_reg - 8'(H);
                end else begin
                    row_reg <= ym_reg[RowW-1:0];
                end
            end
            ST_DR_WR: begin
                cnt_reg  <= cnt_reg + 5'd1;
                row_reg  <= (row_reg == RowW'(H - 1)) ? '0 : row_reg + 1'b1;
                flag_reg <= flag_reg | (|(fq & fmask));
                vf_val_reg <= {7'd0, flag_reg | (|(fq & fmask))};
            end
            ST_DONE: begin
                if (!m_valid || m_ready) begin
                    m_pc               <= pc_reg;
                    m_index_reg        <= index_reg;
                    m_waiting_for_key  <= kwa_reg;
                    m_delay_load_valid <= dly_reg;
                    m_sound_load_valid <= snd_reg;
                    m_timer_load_value <= tval_reg;
                    m_read_byte        <= rbyte_reg;
                    m_row_bits         <= rbits_reg;
                    m_unknown_opcode   <= unk_reg;
                end
            end
            default: ;
        endcase
    end

endmodule : chip8_instruction_execute_unit
`default_nettype wire

// ----- tb/sv/tb_chip8_instruction_execute_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute_unit
// Self-checking bench for the CHIP-8 instruction execute unit. Drives opcodes
// and memory/display service transfers with random gaps and output stalls,
// predicts every result with a behavioral copy of the machine state, and
// compares each field of each output transfer in order.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_execute_unit;
    import c8x_pkg::*;

    localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE_IMM = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4, OP_SE_REG = 4'h5, OP_LD_IMM = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7, OP_ALU = 4'h8, OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I = 4'hA, OP_JP_V0 = 4'hB, OP_RND = 4'hC, OP_DRW = 4'hD;
    localparam logic [3:0] OP_KEY = 4'hE, OP_MISC = 4'hF;
    localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;
    localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
    localparam logic [7:0] F_LD_DT = 8'h07, F_WAIT = 8'h0A, F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18, F_ADD_I = 8'h1E, F_FONT = 8'h29;
    localparam logic [7:0] F_BCD = 8'h33, F_STORE = 8'h55, F_LOAD = 8'h65;
    localparam logic [15:0] OPC_CLS = 16'h00E0, OPC_RET = 16'h00EE;
    localparam logic [11:0] DATA_AREA = 12'h300;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        c8x_action_t action;
        logic [15:0] opcode;
        logic [7:0]  random_byte;
        logic [15:0] key_mask;
        logic [7:0]  delay_now;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [4:0]  row_index;
    } step_in_t;

    typedef struct {
        logic [11:0] pc;
        logic [11:0] index_reg;
        logic        waiting_for_key;
        logic        delay_load_valid;
        logic        sound_load_valid;
        logic [7:0]  timer_load_value;
        logic [7:0]  read_byte;
        logic [63:0] row_bits;
        logic        unknown_opcode;
    } step_out_t;

    class chip8_scoreboard;
        logic [7:0]  vreg [16];
        logic [11:0] pc, index_val, start_addr, font_addr;
        logic [11:0] stack [16];
        bit          stack_set [16];
        logic [3:0]  sp;
        logic [7:0]  memory [4096];
        bit          mem_set [4096];
        logic [63:0] screen [32];
        bit          key_wait;
        logic [3:0]  held_key;
        step_out_t   pending [$];
        int          errors;

        function new();
            start_addr = C8X_START_RESET;
            font_addr  = C8X_FONT_RESET;
            pc = start_addr;
            index_val = '0;
            sp = '0;
            key_wait = 0;
            held_key = '0;
            errors = 0;
            foreach (vreg[i]) vreg[i] = '0;
            foreach (screen[i]) screen[i] = '0;
            foreach (stack_set[i]) stack_set[i] = 0;
            foreach (mem_set[i]) mem_set[i] = 0;
        endfunction

        function void write_reg(c8x_reg_t r, logic [31:0] value);
            if (r == REG_START_ADDRESS) begin
                start_addr = value[11:0];
                pc = start_addr;
            end else begin
                font_addr = value[11:0];
            end
        endfunction

        // Reject items that would read a byte or stack slot never written.
        function bit is_safe(step_in_t it);
            logic [3:0] x;
            x = it.opcode[11:8];
            if (it.action == ACT_READ) return mem_set[it.mem_addr];
            if (it.action != ACT_EXEC) return 1;
            if (it.opcode == OPC_RET) return stack_set[sp - 4'd1];
            if (it.opcode[15:12] == OP_DRW) begin
                for (int i = 0; i < it.opcode[3:0]; i++)
                    if (!mem_set[index_val + 12'(i)]) return 0;
            end
            if (it.opcode[15:12] == OP_MISC && it.opcode[7:0] == F_LOAD) begin
                for (int i = 0; i <= x; i++)
                    if (!mem_set[index_val + 12'(i)]) return 0;
            end
            return 1;
        endfunction

        function void put_byte(logic [11:0] a, logic [7:0] d);
            memory[a] = d;
            mem_set[a] = 1;
        endfunction

        function void execute(step_in_t it, inout step_out_t r);
            logic [15:0] op;
            logic [3:0]  x, y, n;
            logic [7:0]  kk, vx, vy, bits;
            logic [11:0] nnn;
            logic [8:0]  sum;
            logic [5:0]  col;
            logic [4:0]  row;
            bit          flag;
            op = it.opcode;
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            kk = op[7:0];
            nnn = op[11:0];
            vx = vreg[x];
            vy = vreg[y];
            pc = pc + 12'd2;
            case (op[15:12])
                OP_SYS: begin
                    if (op == OPC_CLS) begin
                        foreach (screen[i]) screen[i] = '0;
                    end else if (op == OPC_RET) begin
                        sp = sp - 4'd1;
                        pc = stack[sp];
                    end else begin
                        r.unknown_opcode = 1;
                    end
                end
                OP_JP: pc = nnn;
                OP_CALL: begin
                    stack[sp] = pc;
                    stack_set[sp] = 1;
                    sp = sp + 4'd1;
                    pc = nnn;
                end
                OP_SE_IMM: if (vx == kk) pc = pc + 12'd2;
                OP_SNE_IMM: if (vx != kk) pc = pc + 12'd2;
                OP_SE_REG: begin
                    if (n != 0) r.unknown_opcode = 1;
                    else if (vx == vy) pc = pc + 12'd2;
                end
                OP_LD_IMM: vreg[x] = kk;
                OP_ADD_IMM: vreg[x] = vx + kk;
                OP_ALU: begin
                    case (n)
                        ALU_MOV: vreg[x] = vy;
                        ALU_OR:  vreg[x] = vx | vy;
                        ALU_AND: vreg[x] = vx & vy;
                        ALU_XOR: vreg[x] = vx ^ vy;
                        ALU_ADD: begin
                            sum = {1'b0, vx} + {1'b0, vy};
                            vreg[x] = sum[7:0];
                            vreg[15] = {7'd0, sum[8]};
                        end
                        ALU_SUB: begin
                            vreg[x] = vx - vy;
                            vreg[15] = {7'd0, vx >= vy};
                        end
                        ALU_SHR: begin
                            vreg[x] = vx >> 1;
                            vreg[15] = {7'd0, vx[0]};
                        end
                        ALU_SUBN: begin
                            vreg[x] = vy - vx;
                            vreg[15] = {7'd0, vy >= vx};
                        end
                        ALU_SHL: begin
                            vreg[x] = vx << 1;
                            vreg[15] = {7'd0, vx[7]};
                        end
                        default: r.unknown_opcode = 1;
                    endcase
                end
                OP_SNE_REG: begin
                    if (n != 0) r.unknown_opcode = 1;
                    else if (vx != vy) pc = pc + 12'd2;
                end
                OP_LD_I: index_val = nnn;
                OP_JP_V0: pc = nnn + 12'(vreg[0]);
                OP_RND: vreg[x] = it.random_byte & kk;
                OP_DRW: begin
                    flag = 0;
                    for (int i = 0; i < n; i++) begin
                        bits = memory[index_val + 12'(i)];
                        row = vy[4:0] + 5'(i);
                        for (int b = 0; b < 8; b++) begin
                            if (bits[7 - b]) begin
                                col = vx[5:0] + 6'(b);
                                if (screen[row][63 - col]) flag = 1;
                                screen[row][63 - col] ^= 1'b1;
                            end
                        end
                    end
                    vreg[15] = {7'd0, flag};
                end
                OP_KEY: begin
                    if (kk == KEY_DOWN) begin
                        if (it.key_mask[vx[3:0]]) pc = pc + 12'd2;
                    end else if (kk == KEY_UP) begin
                        if (!it.key_mask[vx[3:0]]) pc = pc + 12'd2;
                    end else begin
                        r.unknown_opcode = 1;
                    end
                end
                default: begin
                    case (kk)
                        F_LD_DT: vreg[x] = it.delay_now;
                        F_WAIT: begin
                            if (!key_wait) begin
                                for (int k = 0; k < 16; k++) begin
                                    if (it.key_mask[k] && !key_wait) begin
                                        held_key = 4'(k);
                                        key_wait = 1;
                                    end
                                end
                                pc = pc - 12'd2;
                            end else if (!it.key_mask[held_key]) begin
                                vreg[x] = {4'd0, held_key};
                                key_wait = 0;
                            end else begin
                                pc = pc - 12'd2;
                            end
                        end
                        F_SET_DT: begin
                            r.delay_load_valid = 1;
                            r.timer_load_value = vx;
                        end
                        F_SET_ST: begin
                            r.sound_load_valid = 1;
                            r.timer_load_value = vx;
                        end
                        F_ADD_I: index_val = index_val + 12'(vx);
                        F_FONT: index_val = font_addr + 12'd5 * 12'(vx);
                        F_BCD: begin
                            put_byte(index_val, vx / 100);
                            put_byte(index_val + 12'd1, (vx / 10) % 10);
                            put_byte(index_val + 12'd2, vx % 10);
                        end
                        F_STORE: begin
                            for (int i = 0; i <= x; i++) put_byte(index_val + 12'(i), vreg[i]);
                            index_val = index_val + 12'(x) + 12'd1;
                        end
                        F_LOAD: begin
                            for (int i = 0; i <= x; i++) vreg[i] = memory[index_val + 12'(i)];
                            index_val = index_val + 12'(x) + 12'd1;
                        end
                        default: r.unknown_opcode = 1;
                    endcase
                end
            endcase
        endfunction

        function void note_input(step_in_t it);
            step_out_t r;
            r = '{default: '0};
            case (it.action)
                ACT_WRITE: put_byte(it.mem_addr, it.mem_data);
                ACT_READ:  r.read_byte = memory[it.mem_addr];
                ACT_ROW:   r.row_bits = screen[it.row_index];
                default:   execute(it, r);
            endcase
            r.pc = pc;
            r.index_reg = index_val;
            r.waiting_for_key = key_wait;
            pending.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] expv, logic [63:0] actv);
            if (expv !== actv) begin
                errors++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, field, expv, actv);
            end
        endfunction

        function void check_result(step_out_t a);
            step_out_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result transfer, pc %0h", $time, a.pc);
                return;
            end
            e = pending.pop_front();
            compare("pc", e.pc, a.pc);
            compare("index_reg", e.index_reg, a.index_reg);
            compare("waiting_for_key", e.waiting_for_key, a.waiting_for_key);
            compare("delay_load_valid", e.delay_load_valid, a.delay_load_valid);
            compare("sound_load_valid", e.sound_load_valid, a.sound_load_valid);
            compare("timer_load_value", e.timer_load_value, a.timer_load_value);
            compare("read_byte", e.read_byte, a.read_byte);
            compare("row_bits", e.row_bits, a.row_bits);
            compare("unknown_opcode", e.unknown_opcode, a.unknown_opcode);
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [1:0]  s_action;
    logic [15:0] s_opcode, s_key_mask;
    logic [7:0]  s_random_byte, s_delay_now, s_mem_data;
    logic [11:0] s_mem_addr;
    logic [4:0]  s_row_index;
    logic        m_valid, m_ready;
    logic [11:0] m_pc, m_index_reg;
    logic        m_waiting_for_key, m_delay_load_valid, m_sound_load_valid;
    logic [7:0]  m_timer_load_value, m_read_byte;
    logic [63:0] m_row_bits;
    logic        m_unknown_opcode;

    chip8_scoreboard sb = new();
    int cycles = 0;

    chip8_instruction_execute_unit dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (pick_gap() > 0) begin
                m_ready <= 0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_pc, m_index_reg, m_waiting_for_key, m_delay_load_valid,
                              m_sound_load_valid, m_timer_load_value, m_read_byte,
                              m_row_bits, m_unknown_opcode});
    end

    task automatic reg_write(c8x_reg_t r, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.write_reg(r, value);
    endtask

    task automatic send(step_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_action <= it.action;
        s_opcode <= it.opcode;
        s_random_byte <= it.random_byte;
        s_key_mask <= it.key_mask;
        s_delay_now <= it.delay_now;
        s_mem_addr <= it.mem_addr;
        s_mem_data <= it.mem_data;
        s_row_index <= it.row_index;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic drain();
        @(posedge aclk);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic step_in_t noise();
        step_in_t it;
        it.action = ACT_EXEC;
        it.opcode = 16'($urandom);
        it.random_byte = 8'($urandom);
        it.key_mask = 16'($urandom);
        it.delay_now = 8'($urandom);
        it.mem_addr = 12'($urandom);
        it.mem_data = 8'($urandom);
        it.row_index = 5'($urandom);
        return it;
    endfunction

    task automatic run_op(logic [15:0] op, logic [15:0] keys);
        step_in_t it;
        it = noise();
        it.opcode = op;
        it.key_mask = keys;
        send(it);
    endtask

    task automatic run_service(c8x_action_t act, logic [11:0] a, logic [7:0] d);
        step_in_t it;
        it = noise();
        it.action = act;
        it.mem_addr = a;
        it.mem_data = d;
        it.row_index = a[4:0];
        send(it);
    endtask

    function automatic step_in_t random_item();
        step_in_t it;
        logic [7:0] fops [9];
        logic [3:0] aops [9];
        int p;
        fops = '{F_LD_DT, F_WAIT, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT, F_BCD, F_STORE, F_LOAD};
        aops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
                 ALU_SHL};
        it = noise();
        p = $urandom_range(0, 99);
        if (p < 12) it.action = ACT_WRITE;
        else if (p < 20) it.action = ACT_READ;
        else if (p < 26) it.action = ACT_ROW;
        if (it.action == ACT_READ && $urandom_range(0, 1))
            it.mem_addr = DATA_AREA + 12'($urandom_range(0, 63));
        if (it.action != ACT_EXEC) return it;
        p = $urandom_range(0, 9);
        case (it.opcode[15:12])
            OP_SYS: if (p < 8) it.opcode = (p < 3) ? OPC_CLS : OPC_RET;
            OP_ALU: if (p < 9) it.opcode[3:0] = aops[$urandom_range(0, 8)];
            OP_SE_REG, OP_SNE_REG: if (p < 8) it.opcode[3:0] = 4'd0;
            OP_LD_I: if (p < 8) it.opcode[11:0] = DATA_AREA + 12'($urandom_range(0, 40));
            OP_DRW: if (p < 8) it.opcode[3:0] = 4'($urandom_range(0, 5));
            OP_KEY: if (p < 9) it.opcode[7:0] = (p < 5) ? KEY_DOWN : KEY_UP;
            OP_MISC: if (p < 9) it.opcode[7:0] = fops[$urandom_range(0, 8)];
            default: ;
        endcase
        p = $urandom_range(0, 9);
        if (p < 3) it.key_mask = '0;
        else if (p < 7) it.key_mask = 16'(1) << $urandom_range(0, 15);
        return it;
    endfunction

    task automatic random_phase(int count);
        step_in_t it;
        int tries;
        for (int k = 0; k < count; k++) begin
            tries = 0;
            do begin
                it = random_item();
                tries++;
            end while (!sb.is_safe(it) && tries < 30);
            if (!sb.is_safe(it)) it.action = ACT_WRITE;
            send(it);
        end
    endtask

    initial begin
        aresetn = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        s_valid = 0;
        s_action = ACT_EXEC;
        s_opcode = '0;
        s_random_byte = '0;
        s_key_mask = '0;
        s_delay_now = '0;
        s_mem_addr = '0;
        s_mem_data = '0;
        s_row_index = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        reg_write(REG_FONT_BASE, 32'(DATA_AREA));
        for (int a = 0; a < 64; a++)
            run_service(ACT_WRITE, DATA_AREA + 12'(a), 8'($urandom));
        run_service(ACT_WRITE, 12'hFFF, 8'hFF);
        run_service(ACT_READ, 12'hFFF, 8'h00);

        // directed: extremes, selected opcode groups, special cases
        run_op(16'h6AFF, 16'h0000);
        run_op(16'h6B01, 16'hFFFF);
        run_op({OP_ALU, 4'hA, 4'hB, ALU_ADD}, 16'h0000);
        run_op({OP_ALU, 4'hC, 4'hA, ALU_SUB}, 16'h0000);
        run_op({OP_ALU, 4'hA, 4'hB, ALU_SHL}, 16'h0000);
        run_op({OP_ALU, 4'hA, 4'hB, ALU_SUBN}, 16'h0000);
        run_op({OP_LD_I, DATA_AREA}, 16'h0000);
        run_op({OP_DRW, 4'h0, 4'hA, 4'h5}, 16'h0000);
        run_op({OP_DRW, 4'h0, 4'hA, 4'h5}, 16'h0000);
        run_op({OP_DRW, 4'h1, 4'h2, 4'h0}, 16'h0000);
        run_op(16'h6FFE, 16'h0000);
        run_op({OP_DRW, 4'hF, 4'hF, 4'h3}, 16'h0000);
        run_service(ACT_ROW, 12'd31, 8'd0);
        run_op(16'h6E25, 16'h0000);
        run_op({OP_MISC, 4'hE, F_FONT}, 16'h0000);
        run_op({OP_CALL, 12'h400}, 16'h0000);
        run_op(OPC_RET, 16'h0000);
        run_op(16'h0123, 16'h0000);
        run_op(16'h5121, 16'h0000);
        run_op(16'h812F, 16'h0000);
        run_op(16'hE1FF, 16'h0000);
        run_op({OP_KEY, 4'hE, KEY_DOWN}, 16'h0020);
        run_op({OP_MISC, 4'h3, F_WAIT}, 16'h0010);
        run_op({OP_MISC, 4'h3, F_WAIT}, 16'h0010);
        run_op({OP_MISC, 4'h3, F_WAIT}, 16'h0000);
        drain();

        reg_write(REG_START_ADDRESS, 32'd0);
        reg_write(REG_FONT_BASE, 32'd0);
        random_phase(600);
        drain();
        reg_write(REG_START_ADDRESS, 32'hFFF);
        reg_write(REG_FONT_BASE, 32'hFFF);
        random_phase(600);
        drain();
        reg_write(REG_START_ADDRESS, 32'($urandom));
        reg_write(REG_FONT_BASE, 32'(DATA_AREA));
        random_phase(800);
        drain();

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
